FILE: hdl/cursor_list_engine_unit_assert.svh
// assertion macros for the cursor list engine, sampled on clk and disabled in reset
`ifndef CURSOR_LIST_ENGINE_UNIT_ASSERT_SVH
`define CURSOR_LIST_ENGINE_UNIT_ASSERT_SVH

// condition holds at every edge
`define CLE_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("cle check failed");

// consequent holds in the same cycle
`define CLE_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cle implication failed");

// consequent holds in the cycle after the antecedent
`define CLE_FOLLOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cle sequence failed");

`endif

FILE: hdl/cle_pkg.sv
// shared types and constants of the cursor list engine
`default_nettype none

package cle_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int WORD_W       = 32;
  localparam int COUNT_W      = 7;
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_ERASE  = 3'd1,
    KIND_BEGIN  = 3'd2,
    KIND_END    = 3'd3,
    KIND_FWD    = 3'd4,
    KIND_BACK   = 3'd5,
    KIND_PRINT  = 3'd6,
    KIND_SIZE   = 3'd7
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_AT_END   = 3'd2,
    ST_AT_BEGIN = 3'd3,
    ST_NO_PRINT = 3'd4
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/cursor_list_engine_unit.sv
// cursor list engine: doubly linked list in link memories with one cursor
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  in_     | in  | in_valid/in_stall  | in_kind, in_word_in
//  out_    | out | out_valid/out_stall| out_word_out, out_has_word, out_count,
//          |     |                    | out_status, out_last
//
// after reset a sweep writes all CAPACITY+2 nodes of the link memories, in_stall high
// one command at a time: insert runs INS_A, INS_B, erase ERS_A, ERS_B, begin/step
//   MOVE or BACK, each then RESP; end/size and flagged insert/erase/forward/print go
//   straight to RESP; the steps are set by the single write port of each link memory
// print emits one element per cycle unless stalled (link read feeds next read address)
// the result register lets a new command be taken while a result waits on out_stall
`default_nettype none

module cursor_list_engine_unit #(
  parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic [cle_pkg::KIND_W-1:0]       in_kind,
  input  wire logic signed [cle_pkg::WORD_W-1:0] in_word_in,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic signed [cle_pkg::WORD_W-1:0] out_word_out,
  output      logic                             out_has_word,
  output      logic [cle_pkg::COUNT_W-1:0]      out_count,
  output      logic [cle_pkg::STATUS_W-1:0]     out_status,
  output      logic                             out_last
);

  localparam int NODES = CAPACITY + 2;
  localparam int IW    = $clog2(NODES);
  localparam int SW    = $clog2(CAPACITY);
  localparam int CW    = cle_pkg::COUNT_W;
  localparam int WW    = cle_pkg::WORD_W;

  localparam logic [IW-1:0] HEAD      = IW'(CAPACITY);
  localparam logic [IW-1:0] TAIL      = IW'(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
  localparam logic [IW-1:0] LAST_NODE = IW'(NODES - 1);
  localparam logic [CW-1:0] CNT_CAP   = CW'(CAPACITY);
  localparam logic [CW-1:0] PK_LAST   = CW'(CAPACITY - 1);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_INS_A, ST_INS_B, ST_ERS_A, ST_ERS_B,
    ST_MOVE, ST_BACK, ST_PRINT, ST_RESP
  } state_t;

  function automatic logic [IW-1:0] next_rst(input logic [IW-1:0] i);
    logic [IW-1:0] r;
    if (i < LAST_SLOT) r = i + IW'(1);
    else if (i == LAST_SLOT || i == HEAD) r = TAIL;
    else r = '0;
    return r;
  endfunction

  function automatic logic [IW-1:0] prev_rst(input logic [IW-1:0] i);
    return (i == TAIL) ? HEAD : '0;
  endfunction

  // memories
  logic [IW-1:0] nx_mem [NODES];
  logic [IW-1:0] pv_mem [NODES];
  logic [WW-1:0] wd_mem [CAPACITY];

  logic          nx_we, nx_re, pv_we, pv_re, wd_we, wd_re;
  logic [IW-1:0] nx_wa, nx_wd, nx_ra, pv_wa, pv_wd, pv_ra;
  logic [SW-1:0] wd_wa, wd_ra;
  logic [WW-1:0] wd_wd;
  logic [IW-1:0] nx_rd_r, pv_rd_r;
  logic [WW-1:0] wd_rd_r;

  always_ff @(posedge clk) begin
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    if (nx_re) nx_rd_r <= nx_mem[nx_ra];
  end

  always_ff @(posedge clk) begin
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    if (pv_re) pv_rd_r <= pv_mem[pv_ra];
  end

  always_ff @(posedge clk) begin
    if (wd_we) wd_mem[wd_wa] <= wd_wd;
    if (wd_re) wd_rd_r <= wd_mem[wd_ra];
  end

  // control and result registers
  state_t               state_r, state_nxt;
  logic [IW-1:0]        cursor_r, cursor_nxt;
  logic [IW-1:0]        free_head_r, free_head_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [IW-1:0]        init_r, init_nxt;
  logic [CW-1:0]        pk_r, pk_nxt;
  cle_pkg::status_t     status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WW-1:0]        out_word_r, out_word_nxt;
  logic                 out_has_r, out_has_nxt;
  logic [CW-1:0]        out_count_r, out_count_nxt;
  cle_pkg::status_t     out_status_r, out_status_nxt;
  logic                 out_last_r, out_last_nxt;

  logic out_free, out_load, cur_is_slot, pr_fin;

  assign out_free    = !out_valid_r || !out_stall;
  assign cur_is_slot = cursor_r < HEAD;
  assign pr_fin      = (nx_rd_r >= HEAD) || (pk_r == PK_LAST);

  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    free_head_nxt  = free_head_r;
    count_nxt      = count_r;
    init_nxt       = init_r;
    pk_nxt         = pk_r;
    status_nxt     = status_r;
    out_load       = 1'b0;
    out_word_nxt   = out_word_r;
    out_has_nxt    = out_has_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    nx_we = 1'b0; nx_wa = cursor_r; nx_wd = free_head_r;
    pv_we = 1'b0; pv_wa = cursor_r; pv_wd = free_head_r;
    nx_re = 1'b0; nx_ra = cursor_r;
    pv_re = 1'b0; pv_ra = cursor_r;
    wd_we = 1'b0; wd_wa = free_head_r[SW-1:0]; wd_wd = in_word_in;
    wd_re = 1'b0; wd_ra = cursor_r[SW-1:0];

    unique case (state_r)
      ST_INIT: begin
        nx_we    = 1'b1;
        nx_wa    = init_r;
        nx_wd    = next_rst(init_r);
        pv_we    = 1'b1;
        pv_wa    = init_r;
        pv_wd    = prev_rst(init_r);
        init_nxt = init_r + IW'(1);
        if (init_r == LAST_NODE) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          status_nxt = cle_pkg::ST_OK;
          state_nxt  = ST_RESP;
          unique case (cle_pkg::kind_t'(in_kind))
            cle_pkg::KIND_INSERT: begin
              if (count_r >= CNT_CAP) begin
                status_nxt = cle_pkg::ST_FULL;
              end else begin
                wd_we     = 1'b1;
                nx_re     = 1'b1;
                nx_ra     = free_head_r;
                pv_re     = 1'b1;
                state_nxt = ST_INS_A;
              end
            end
            cle_pkg::KIND_ERASE: begin
              if (!cur_is_slot) begin
                status_nxt = cle_pkg::ST_AT_END;
              end else begin
                nx_re     = 1'b1;
                pv_re     = 1'b1;
                state_nxt = ST_ERS_A;
              end
            end
            cle_pkg::KIND_BEGIN: begin
              nx_re     = 1'b1;
              nx_ra     = HEAD;
              state_nxt = ST_MOVE;
            end
            cle_pkg::KIND_END: begin
              cursor_nxt = TAIL;
            end
            cle_pkg::KIND_FWD: begin
              if (!cur_is_slot) begin
                status_nxt = cle_pkg::ST_AT_END;
              end else begin
                nx_re     = 1'b1;
                state_nxt = ST_MOVE;
              end
            end
            cle_pkg::KIND_BACK: begin
              pv_re     = 1'b1;
              state_nxt = ST_BACK;
            end
            cle_pkg::KIND_PRINT: begin
              if (!cur_is_slot) begin
                status_nxt = cle_pkg::ST_NO_PRINT;
              end else begin
                wd_re     = 1'b1;
                nx_re     = 1'b1;
                pk_nxt    = '0;
                state_nxt = ST_PRINT;
              end
            end
            cle_pkg::KIND_SIZE: begin
              status_nxt = cle_pkg::ST_OK;
            end
            default: begin
              status_nxt = cle_pkg::ST_OK;
            end
          endcase
        end
      end
      ST_INS_A: begin
        // splice new slot after the node before the cursor
        nx_we     = 1'b1;
        nx_wa     = pv_rd_r;
        nx_wd     = free_head_r;
        pv_we     = 1'b1;
        pv_wa     = free_head_r;
        pv_wd     = pv_rd_r;
        state_nxt = ST_INS_B;
      end
      ST_INS_B: begin
        nx_we         = 1'b1;
        nx_wa         = free_head_r;
        nx_wd         = cursor_r;
        pv_we         = 1'b1;
        pv_wa         = cursor_r;
        pv_wd         = free_head_r;
        free_head_nxt = nx_rd_r;
        count_nxt     = count_r + CW'(1);
        state_nxt     = ST_RESP;
      end
      ST_ERS_A: begin
        nx_we     = 1'b1;
        nx_wa     = pv_rd_r;
        nx_wd     = nx_rd_r;
        pv_we     = 1'b1;
        pv_wa     = nx_rd_r;
        pv_wd     = pv_rd_r;
        state_nxt = ST_ERS_B;
      end
      ST_ERS_B: begin
        // freed slot goes to the front of the free chain
        nx_we         = 1'b1;
        nx_wa         = cursor_r;
        nx_wd         = free_head_r;
        free_head_nxt = cursor_r;
        if (count_r != '0) count_nxt = count_r - CW'(1);
        cursor_nxt    = nx_rd_r;
        state_nxt     = ST_RESP;
      end
      ST_MOVE: begin
        cursor_nxt = nx_rd_r;
        state_nxt  = ST_RESP;
      end
      ST_BACK: begin
        if (pv_rd_r == HEAD) status_nxt = cle_pkg::ST_AT_BEGIN;
        else cursor_nxt = pv_rd_r;
        state_nxt = ST_RESP;
      end
      ST_PRINT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_word_nxt   = wd_rd_r;
          out_has_nxt    = 1'b1;
          out_count_nxt  = count_r;
          out_status_nxt = cle_pkg::ST_OK;
          out_last_nxt   = pr_fin;
          if (pr_fin) begin
            cursor_nxt = TAIL;
            state_nxt  = ST_IDLE;
          end else begin
            // read data holds while stalled, so follow the link only on emit
            wd_re  = 1'b1;
            wd_ra  = nx_rd_r[SW-1:0];
            nx_re  = 1'b1;
            nx_ra  = nx_rd_r;
            pk_nxt = pk_r + CW'(1);
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_word_nxt   = '0;
          out_has_nxt    = 1'b0;
          out_count_nxt  = count_r;
          out_status_nxt = status_r;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_r      <= '0;
      cursor_r    <= TAIL;
      free_head_r <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_r       <= init_nxt;
      cursor_r     <= cursor_nxt;
      free_head_r  <= free_head_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      pk_r         <= pk_nxt;
      status_r     <= status_nxt;
      out_word_r   <= out_word_nxt;
      out_has_r    <= out_has_nxt;
      out_count_r  <= out_count_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_word_out = out_word_r;
  assign out_has_word = out_has_r;
  assign out_count    = out_count_r;
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;

`include "cursor_list_engine_unit_assert.svh"

  `CLE_CHECK(a_count_bound, count_r <= CNT_CAP)
  `CLE_CHECK(a_cursor_not_head, cursor_r != HEAD)
  `CLE_IMPLY(a_free_slot, count_r < CNT_CAP, free_head_r < HEAD)
  `CLE_IMPLY(a_word_ok, out_valid_r && out_has_r, out_status_r == cle_pkg::ST_OK)
  `CLE_FOLLOW(a_print_run, out_valid_r && !out_stall && !out_last_r, out_valid_r)

endmodule

`default_nettype wire

FILE: bench/cursor_list_engine_unit_test.sv
// self-checking testbench of the cursor list engine: commands, list predictor, result checks
module cursor_list_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP        = cle_pkg::CAPACITY_DEF;
  localparam int WW         = cle_pkg::WORD_W;
  localparam int CW         = cle_pkg::COUNT_W;
  localparam int HEAD       = CAP;
  localparam int TAIL       = CAP + 1;
  localparam int HOLD_LEN   = 240;
  localparam int DRAIN_MAX  = 200000;
  localparam int MAX_PRINTS = 60;

  typedef struct packed {
    logic signed [WW-1:0]    word;
    logic                    has;
    logic [CW-1:0]           count;
    cle_pkg::status_t        status;
    logic                    last;
  } list_result_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [cle_pkg::KIND_W-1:0]         in_kind = cle_pkg::KIND_SIZE;
  logic signed [WW-1:0]               in_word_in = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [WW-1:0]               out_word_out;
  logic                               out_has_word;
  logic [CW-1:0]                      out_count;
  logic [cle_pkg::STATUS_W-1:0]       out_status;
  logic                               out_last;

  // predicted list state
  logic signed [WW-1:0]  slot_word [CAP];
  logic [CW-1:0]         fwd_link [CAP+2];
  logic [CW-1:0]         back_link [CAP+2];
  logic [CW-1:0]         free_slot;
  logic [CW-1:0]         elem_count;
  logic [CW-1:0]         cur_node;

  list_result_t pending_results[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  cursor_list_engine_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_word_in  (in_word_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word_out(out_word_out),
    .out_has_word(out_has_word),
    .out_count   (out_count),
    .out_status  (out_status),
    .out_last    (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [WW-1:0] got,
                                 input logic [WW-1:0] want);
    if (fail_count < MAX_PRINTS)
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic clear_list_model();
    for (int i = 0; i < CAP; i++) begin
      slot_word[i] = '0;
      fwd_link[i] = (i + 1 < CAP) ? CW'(i + 1) : CW'(TAIL);
      back_link[i] = '0;
    end
    fwd_link[HEAD] = CW'(TAIL);
    back_link[HEAD] = '0;
    fwd_link[TAIL] = '0;
    back_link[TAIL] = CW'(HEAD);
    free_slot = '0;
    elem_count = '0;
    cur_node = CW'(TAIL);
  endtask

  task automatic push_result(input logic signed [WW-1:0] w, input logic has,
                             input cle_pkg::status_t st, input logic fin);
    list_result_t r;
    r.word = w;
    r.has = has;
    r.count = elem_count;
    r.status = st;
    r.last = fin;
    pending_results.push_back(r);
  endtask

  // update the list model for one accepted command and queue what it emits
  task automatic apply_command(input cle_pkg::kind_t k, input logic signed [WW-1:0] w);
    logic [CW-1:0] cur, slot, prv, nxt;
    cle_pkg::status_t st;
    int emitted;
    cur = cur_node;
    st = cle_pkg::ST_OK;
    emitted = 0;
    case (k)
      cle_pkg::KIND_INSERT: begin
        if (elem_count >= CAP) st = cle_pkg::ST_FULL;
        else begin
          slot = free_slot;
          prv = back_link[cur];
          free_slot = fwd_link[slot];
          slot_word[slot] = w;
          fwd_link[slot] = cur;
          back_link[cur] = slot;
          back_link[slot] = prv;
          fwd_link[prv] = slot;
          elem_count++;
        end
      end
      cle_pkg::KIND_ERASE: begin
        if (cur >= CAP) st = cle_pkg::ST_AT_END;
        else begin
          nxt = fwd_link[cur];
          prv = back_link[cur];
          fwd_link[prv] = nxt;
          back_link[nxt] = prv;
          fwd_link[cur] = free_slot;
          free_slot = cur;
          if (elem_count > 0) elem_count--;
          cur_node = nxt;
        end
      end
      cle_pkg::KIND_BEGIN: cur_node = fwd_link[HEAD];
      cle_pkg::KIND_END: cur_node = CW'(TAIL);
      cle_pkg::KIND_FWD: begin
        if (cur >= CAP) st = cle_pkg::ST_AT_END;
        else cur_node = fwd_link[cur];
      end
      cle_pkg::KIND_BACK: begin
        if (back_link[cur] == HEAD || cur == HEAD) st = cle_pkg::ST_AT_BEGIN;
        else cur_node = back_link[cur];
      end
      cle_pkg::KIND_PRINT: begin
        if (cur >= CAP) st = cle_pkg::ST_NO_PRINT;
        else begin
          nxt = cur;
          while (nxt < CAP && emitted < CAP) begin
            prv = fwd_link[nxt];
            push_result(slot_word[nxt], 1'b1, cle_pkg::ST_OK,
                        (prv >= CAP) || (emitted + 1 >= CAP));
            emitted++;
            nxt = prv;
          end
          cur_node = CW'(TAIL);
        end
      end
      default: ;
    endcase
    if (emitted == 0) push_result('0, 1'b0, st, 1'b1);
  endtask

  // offer one command and hold it until the block takes it
  task automatic send_command(input cle_pkg::kind_t k, input logic signed [WW-1:0] w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_word_in <= w;
    do @(posedge clk); while (in_stall);
    apply_command(k, w);
  endtask

  function automatic logic signed [WW-1:0] pick_word();
    int sel;
    sel = $urandom_range(15);
    case (sel)
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // receiver side: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("transaction with nothing pending", out_word_out, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_word_out !== want.word)
          report_mismatch("word_out", out_word_out, want.word);
        if (out_has_word !== want.has)
          report_mismatch("has_word", WW'(out_has_word), WW'(want.has));
        if (out_count !== want.count)
          report_mismatch("count", WW'(out_count), WW'(want.count));
        if (out_status !== want.status)
          report_mismatch("status", WW'(out_status), WW'(want.status));
        if (out_last !== want.last)
          report_mismatch("last", WW'(out_last), WW'(want.last));
      end
    end
  end

  task automatic test_empty_list();
    send_command(cle_pkg::KIND_SIZE, pick_word());
    send_command(cle_pkg::KIND_PRINT, pick_word());
    send_command(cle_pkg::KIND_BACK, pick_word());
    send_command(cle_pkg::KIND_FWD, pick_word());
    send_command(cle_pkg::KIND_ERASE, pick_word());
    send_command(cle_pkg::KIND_BEGIN, pick_word());
    send_command(cle_pkg::KIND_END, pick_word());
  endtask

  task automatic test_edit_and_walk();
    send_command(cle_pkg::KIND_INSERT, 32'sh7fff_ffff);
    send_command(cle_pkg::KIND_INSERT, 32'sh8000_0000);
    send_command(cle_pkg::KIND_INSERT, -32'sd1);
    send_command(cle_pkg::KIND_INSERT, '0);
    send_command(cle_pkg::KIND_INSERT, 32'sh5a5a_a5a5);
    send_command(cle_pkg::KIND_BEGIN, '0);
    send_command(cle_pkg::KIND_BACK, '0);
    send_command(cle_pkg::KIND_FWD, '0);
    // erase in the middle leaves the cursor on the following word
    send_command(cle_pkg::KIND_ERASE, '0);
    send_command(cle_pkg::KIND_BACK, '0);
    send_command(cle_pkg::KIND_PRINT, '0);
    send_command(cle_pkg::KIND_SIZE, '0);
    send_command(cle_pkg::KIND_BEGIN, '0);
    send_command(cle_pkg::KIND_PRINT, '0);
    send_command(cle_pkg::KIND_END, '0);
    send_command(cle_pkg::KIND_INSERT, 32'shffff_0000);
  endtask

  // output held off while inserts keep coming, then full-list cases and a full print
  task automatic test_fill_under_backpressure();
    hold_left = HOLD_LEN;
    while (elem_count < CAP) send_command(cle_pkg::KIND_INSERT, pick_word());
    send_command(cle_pkg::KIND_INSERT, pick_word());
    send_command(cle_pkg::KIND_INSERT, pick_word());
    send_command(cle_pkg::KIND_BEGIN, pick_word());
    send_command(cle_pkg::KIND_PRINT, pick_word());
    send_command(cle_pkg::KIND_SIZE, pick_word());
  endtask

  task automatic test_random_commands(input int n);
    int ins_w, pick;
    cle_pkg::kind_t k;
    for (int i = 0; i < n; i++) begin
      // favor inserts on a short list and edits on a long one
      ins_w = (elem_count < 10) ? 45 : (elem_count > 54) ? 12 : 28;
      pick = $urandom_range(ins_w + 79);
      if (pick < ins_w) k = cle_pkg::KIND_INSERT;
      else begin
        pick = pick - ins_w;
        if (pick < 22) k = cle_pkg::KIND_ERASE;
        else if (pick < 30) k = cle_pkg::KIND_BEGIN;
        else if (pick < 34) k = cle_pkg::KIND_END;
        else if (pick < 50) k = cle_pkg::KIND_FWD;
        else if (pick < 64) k = cle_pkg::KIND_BACK;
        else if (pick < 72) k = cle_pkg::KIND_PRINT;
        else k = cle_pkg::KIND_SIZE;
      end
      send_command(k, pick_word());
    end
  endtask

  initial begin
    int guard;
    clear_list_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 56;
    test_empty_list();
    test_edit_and_walk();
    test_random_commands(60);

    send_idle_pct = 56;
    recv_idle_pct = 13;
    test_random_commands(60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_fill_under_backpressure();
    test_random_commands(60);

    in_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_MAX) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", WW'(pending_results.size()), '0);

    if (fail_count == 0) begin
      $display("cursor_list_engine_unit regression: pass");
    end else begin
      $display("cursor_list_engine_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("cursor_list_engine_unit regression: fail");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/cle_pkg.sv
hdl/cursor_list_engine_unit.sv
bench/cursor_list_engine_unit_test.sv
